// ===== rtl/core/abff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_pkg
// Shared types and constants of the allocation bitmap free finder.
// ----------------------------------------------------------------------------
package abff_pkg;

	localparam int unsigned CNT_W      = 13;
	localparam int unsigned IDX_W      = 12;
	localparam int unsigned ACT_W      = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned CNT_MAX    = 8191;
	localparam int unsigned BITS_RST   = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_BITS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_SET    = 2'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_GET   = 2'd0,
		ACT_SET   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_FIND  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SCAN_FIND  = 2'd0,
		SCAN_ABOVE = 2'd1,
		SCAN_BELOW = 2'd2
	} scan_mode_t;

	typedef enum logic [2:0] {
		ST_FILL      = 3'd0,
		ST_IDLE      = 3'd1,
		ST_CHECK     = 3'd2,
		ST_DIV       = 3'd3,
		ST_DATA      = 3'd4,
		ST_DOWN      = 3'd5,
		ST_SCAN_UP   = 3'd6,
		ST_SCAN_DOWN = 3'd7
	} state_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] bit_index;
	} in_item_t;

	typedef struct packed {
		logic             ok;
		logic             bit_value;
		logic [IDX_W-1:0] found_index;
	} out_item_t;

	typedef struct packed {
		logic       accept;
		logic       calc_q;
		logic       calc_base;
		logic       wr_set;
		logic       wr_clr;
		logic       scan_init;
		scan_mode_t scan_mode;
		logic       scan_step;
		logic       take_low;
		logic       take_high;
		logic       mark_full;
		logic       fill_step;
		logic       emit;
		logic       emit_ok;
		logic       emit_val;
		logic       emit_found;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    fail;
		logic    bit_set;
		logic    full;
		logic    idx_is_low;
		logic    idx_is_high;
		logic    idx_zero;
		logic    scan_hit;
		logic    scan_end;
		logic    fill_last;
		logic    refill;
	} status_t;

endpackage

// ===== rtl/core/allocation_bitmap_free_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_bitmap_free_finder
// Allocation bitmap with tracked lowest and highest clear bit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high, and cannot be
// held off by the receiver. Get, clear, a set that moves no bound, and
// items that fail the range or full check give their result without a
// scan; a set that moves a bound, and find, walk the store one word per
// cycle through the RAM read port, with a single scan of at most
// MAX_BITS/WORD_BITS words (64 at the defaults). After reset and after
// every config write to the bits-in-use or fill-set register the store is
// refilled one word per cycle with busy held high; the config channel is
// always ready and a config write also holds busy for that cycle.
module allocation_bitmap_free_finder #(
	parameter int unsigned MAX_BITS  = 4096,
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  abff_pkg::in_item_t              item,
	output logic                            done,
	output abff_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [abff_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abff_pkg::CFG_DATA_W-1:0] cfg_data
);

	abff_pkg::cmd_t    cmd;
	abff_pkg::status_t status;

	abff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.status    (status),
		.cmd       (cmd)
	);

	abff_dpath #(
		.MAX_BITS  (MAX_BITS),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat longer than one cycle");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result beat right after acceptance");
`endif

endmodule

// ===== rtl/core/abff_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module abff_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/abff_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_dpath
// Bitmap store, bounds, config registers, word scan and result register.
// ----------------------------------------------------------------------------
module abff_dpath #(
	parameter int unsigned MAX_BITS  = 4096,
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  abff_pkg::in_item_t                 item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [abff_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [abff_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  abff_pkg::cmd_t                     cmd,
	output abff_pkg::status_t                  status,
	output logic                               done,
	output abff_pkg::out_item_t                result
);

	localparam int unsigned CW      = abff_pkg::CNT_W;
	localparam int unsigned DEPTH   = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned BW      = $clog2(DEPTH * WORD_BITS);
	localparam int unsigned GW      = ((BW > CW) ? BW : CW) + 1;
	localparam int unsigned PW      = $clog2(WORD_BITS);
	localparam int unsigned SH      = CW + 7;
	localparam int unsigned RW      = SH + 1;
	localparam int unsigned PRODW   = CW + RW;
	localparam int unsigned RECIP   = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned N_CLAMP =
		(MAX_BITS < abff_pkg::CNT_MAX) ? MAX_BITS : abff_pkg::CNT_MAX;
	localparam int unsigned N_RST   =
		(abff_pkg::BITS_RST < MAX_BITS) ? abff_pkg::BITS_RST : MAX_BITS;

	logic [CW-1:0]                 bits_q;
	logic                          fill_q;
	logic [CW-1:0]                 lowest_q;
	logic [CW-1:0]                 highest_q;
	logic [abff_pkg::ACT_W-1:0]    act_q;
	logic [abff_pkg::IDX_W-1:0]    idx_q;
	logic [AW-1:0]                 q_q;
	logic [GW-1:0]                 base_q;
	logic [AW-1:0]                 rd_w_q;
	logic [GW-1:0]                 rd_base_q;
	logic [GW-1:0]                 ev_base_s1;
	logic                          dv_s1;
	logic [CW-1:0]                 lo_q;
	logic [CW-1:0]                 hi_q;
	logic                          up_q;
	logic [AW-1:0]                 fill_cnt_q;
	logic                          done_q;
	abff_pkg::out_item_t           result_q;

	logic                          cfg_hit;
	logic [CW-1:0]                 bits_nx;
	logic                          fill_nx;
	logic [CW-1:0]                 n;
	logic [CW-1:0]                 n_nx;
	logic [CW-1:0]                 nm1;
	logic                          full;
	logic [CW-1:0]                 idx_ext;
	logic [CW-1:0]                 x;
	logic [PRODW-1:0]              prod;
	logic [WORD_BITS-1:0]          rdata;
	logic [WORD_BITS-1:0]          cur_mask;
	logic [WORD_BITS-1:0]          cand;
	logic                          cur_bit;
	logic [PW-1:0]                 pos;
	logic [CW-1:0]                 hit_idx;
	logic                          end_up;
	logic                          end_down;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [WORD_BITS-1:0]          ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [CW-1:0]                 hi_top;
	logic [CW-1:0]                 hi_below;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && cfg_ready &&
		(cfg_index == abff_pkg::REG_BITS_IN_USE || cfg_index == abff_pkg::REG_FILL_SET);
	assign bits_nx   = (cfg_index == abff_pkg::REG_BITS_IN_USE) ? cfg_data : bits_q;
	assign fill_nx   = (cfg_index == abff_pkg::REG_FILL_SET) ? cfg_data[0] : fill_q;

	assign n    = (bits_q > CW'(N_CLAMP)) ? CW'(N_CLAMP) : bits_q;
	assign n_nx = (bits_nx > CW'(N_CLAMP)) ? CW'(N_CLAMP) : bits_nx;
	assign nm1  = n - CW'(1);
	assign full = (lowest_q >= n) || (highest_q >= n);

	assign idx_ext = CW'(idx_q);
	assign x       = (act_q == abff_pkg::ACT_FIND) ? lowest_q : idx_ext;
	assign prod    = PRODW'(x) * PRODW'(RECIP);

	assign hi_top   = (highest_q < nm1) ? highest_q : nm1;
	assign hi_below = ((idx_ext - CW'(1)) < nm1) ? (idx_ext - CW'(1)) : nm1;

	always_comb begin
		for (int k = 0; k < WORD_BITS; k++) begin
			cur_mask[k] = ((base_q + GW'(k)) == GW'(idx_q));
			cand[k]     = !rdata[k] && ((ev_base_s1 + GW'(k)) >= GW'(lo_q)) &&
				((ev_base_s1 + GW'(k)) <= GW'(hi_q));
		end
	end

	always_comb begin
		pos = '0;
		if (up_q) begin
			for (int k = WORD_BITS - 1; k >= 0; k--) begin
				if (cand[k]) begin
					pos = PW'(k);
				end
			end
		end else begin
			for (int k = 0; k < WORD_BITS; k++) begin
				if (cand[k]) begin
					pos = PW'(k);
				end
			end
		end
	end

	assign cur_bit  = |(rdata & cur_mask);
	assign hit_idx  = CW'(ev_base_s1 + GW'(pos));
	assign end_up   = (ev_base_s1 + GW'(WORD_BITS)) > GW'(hi_q);
	assign end_down = ev_base_s1 <= GW'(lo_q);

	always_comb begin
		status             = '0;
		status.act         = abff_pkg::action_t'(act_q);
		status.fail        = (act_q == abff_pkg::ACT_FIND) ? full : (idx_ext >= n);
		status.bit_set     = cur_bit;
		status.full        = full;
		status.idx_is_low  = (idx_ext == lowest_q);
		status.idx_is_high = (idx_ext == highest_q);
		status.idx_zero    = (idx_q == '0);
		status.scan_hit    = dv_s1 && (|cand);
		status.scan_end    = dv_s1 && !(|cand) && (up_q ? end_up : end_down);
		status.fill_last   = (fill_cnt_q == AW'(DEPTH - 1));
		status.refill      = cfg_hit;
	end

	assign ram_we    = cmd.fill_step || cmd.wr_set || cmd.wr_clr;
	assign ram_waddr = cmd.fill_step ? fill_cnt_q : q_q;
	assign ram_raddr = cmd.scan_step ? rd_w_q : q_q;

	always_comb begin
		if (cmd.fill_step) begin
			ram_wdata = {WORD_BITS{fill_q}};
		end else if (cmd.wr_set) begin
			ram_wdata = rdata | cur_mask;
		end else begin
			ram_wdata = rdata & ~cur_mask;
		end
	end

	abff_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// config registers, bounds and fill sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q     <= CW'(abff_pkg::BITS_RST);
			fill_q     <= 1'b0;
			lowest_q   <= '0;
			highest_q  <= CW'(N_RST - 1);
			fill_cnt_q <= '0;
		end else begin
			if (cfg_hit) begin
				bits_q     <= bits_nx;
				fill_q     <= fill_nx;
				fill_cnt_q <= '0;
				if (n_nx == '0 || fill_nx) begin
					lowest_q  <= n_nx;
					highest_q <= n_nx;
				end else begin
					lowest_q  <= '0;
					highest_q <= n_nx - CW'(1);
				end
			end else begin
				if (cmd.fill_step) begin
					fill_cnt_q <= fill_cnt_q + AW'(1);
				end
				if (cmd.mark_full) begin
					lowest_q  <= n;
					highest_q <= n;
				end else if (cmd.wr_clr) begin
					if (full) begin
						lowest_q  <= idx_ext;
						highest_q <= idx_ext;
					end else begin
						if (idx_ext < lowest_q) begin
							lowest_q <= idx_ext;
						end
						if (idx_ext > highest_q) begin
							highest_q <= idx_ext;
						end
					end
				end else if (cmd.take_low) begin
					lowest_q <= hit_idx;
				end else if (cmd.take_high) begin
					highest_q <= hit_idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			dv_s1  <= cmd.scan_step;
			done_q <= cmd.emit;
		end
	end

	// item, divider, scan and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= item.action;
			idx_q <= item.bit_index;
		end
		if (cmd.calc_q) begin
			q_q <= AW'(prod >> SH);
		end
		if (cmd.calc_base) begin
			base_q <= GW'(q_q) * GW'(WORD_BITS);
		end
		if (cmd.scan_init) begin
			rd_w_q    <= q_q;
			rd_base_q <= base_q;
			case (cmd.scan_mode)
				abff_pkg::SCAN_ABOVE: begin
					lo_q <= idx_ext + CW'(1);
					hi_q <= hi_top;
					up_q <= 1'b1;
				end
				abff_pkg::SCAN_BELOW: begin
					lo_q <= lowest_q;
					hi_q <= hi_below;
					up_q <= 1'b0;
				end
				default: begin
					lo_q <= lowest_q;
					hi_q <= hi_top;
					up_q <= 1'b1;
				end
			endcase
		end else if (cmd.scan_step) begin
			if (up_q) begin
				rd_w_q    <= rd_w_q + AW'(1);
				rd_base_q <= rd_base_q + GW'(WORD_BITS);
			end else begin
				rd_w_q    <= rd_w_q - AW'(1);
				rd_base_q <= rd_base_q - GW'(WORD_BITS);
			end
		end
		if (cmd.scan_step) begin
			ev_base_s1 <= rd_base_q;
		end
		if (cmd.emit) begin
			result_q.ok          <= cmd.emit_ok;
			result_q.bit_value   <= cmd.emit_val ? cur_bit : 1'b0;
			result_q.found_index <= cmd.emit_found ? hit_idx[abff_pkg::IDX_W-1:0] : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/abff_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_ctrl
// Sequencer: fill sweep, item decode, bit access and bound scans.
// ----------------------------------------------------------------------------
module abff_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cfg_valid,
	output logic              busy,
	input  abff_pkg::status_t status,
	output abff_pkg::cmd_t    cmd
);

	abff_pkg::state_t state_q;
	abff_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abff_pkg::ST_FILL;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != abff_pkg::ST_IDLE) || cfg_valid;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			abff_pkg::ST_FILL: begin
				if (status.fill_last) begin
					state_nx = abff_pkg::ST_IDLE;
				end
			end
			abff_pkg::ST_IDLE: begin
				if (start && !cfg_valid) begin
					state_nx = abff_pkg::ST_CHECK;
				end
			end
			abff_pkg::ST_CHECK: begin
				state_nx = status.fail ? abff_pkg::ST_IDLE : abff_pkg::ST_DIV;
			end
			abff_pkg::ST_DIV: begin
				state_nx = abff_pkg::ST_DATA;
			end
			abff_pkg::ST_DATA: begin
				case (status.act)
					abff_pkg::ACT_FIND: state_nx = abff_pkg::ST_SCAN_UP;
					abff_pkg::ACT_SET: begin
						if (status.bit_set || status.full) begin
							state_nx = abff_pkg::ST_IDLE;
						end else if (status.idx_is_low) begin
							state_nx = abff_pkg::ST_SCAN_UP;
						end else if (status.idx_is_high) begin
							state_nx = abff_pkg::ST_DOWN;
						end else begin
							state_nx = abff_pkg::ST_IDLE;
						end
					end
					default: state_nx = abff_pkg::ST_IDLE;
				endcase
			end
			abff_pkg::ST_DOWN: begin
				state_nx = status.idx_zero ? abff_pkg::ST_IDLE : abff_pkg::ST_SCAN_DOWN;
			end
			abff_pkg::ST_SCAN_UP: begin
				if (status.scan_hit) begin
					if (status.act != abff_pkg::ACT_FIND && status.idx_is_high) begin
						state_nx = abff_pkg::ST_DOWN;
					end else begin
						state_nx = abff_pkg::ST_IDLE;
					end
				end else if (status.scan_end) begin
					state_nx = abff_pkg::ST_IDLE;
				end
			end
			abff_pkg::ST_SCAN_DOWN: begin
				if (status.scan_hit || status.scan_end) begin
					state_nx = abff_pkg::ST_IDLE;
				end
			end
			default: state_nx = abff_pkg::ST_FILL;
		endcase
		if (status.refill) begin
			state_nx = abff_pkg::ST_FILL;
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			abff_pkg::ST_FILL: begin
				cmd.fill_step = 1'b1;
			end
			abff_pkg::ST_IDLE: begin
				cmd.accept = start && !cfg_valid;
			end
			abff_pkg::ST_CHECK: begin
				cmd.calc_q = 1'b1;
				cmd.emit   = status.fail;
			end
			abff_pkg::ST_DIV: begin
				cmd.calc_base = 1'b1;
			end
			abff_pkg::ST_DATA: begin
				case (status.act)
					abff_pkg::ACT_GET: begin
						cmd.emit     = 1'b1;
						cmd.emit_ok  = 1'b1;
						cmd.emit_val = 1'b1;
					end
					abff_pkg::ACT_CLEAR: begin
						cmd.wr_clr  = status.bit_set;
						cmd.emit    = 1'b1;
						cmd.emit_ok = 1'b1;
					end
					abff_pkg::ACT_FIND: begin
						cmd.scan_init = 1'b1;
						cmd.scan_mode = abff_pkg::SCAN_FIND;
					end
					default: begin
						cmd.wr_set = !status.bit_set;
						if (status.bit_set || status.full) begin
							cmd.emit    = 1'b1;
							cmd.emit_ok = 1'b1;
						end else if (status.idx_is_low) begin
							cmd.scan_init = 1'b1;
							cmd.scan_mode = abff_pkg::SCAN_ABOVE;
						end else if (!status.idx_is_high) begin
							cmd.emit    = 1'b1;
							cmd.emit_ok = 1'b1;
						end
					end
				endcase
			end
			abff_pkg::ST_DOWN: begin
				if (status.idx_zero) begin
					cmd.mark_full = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_ok   = 1'b1;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.scan_mode = abff_pkg::SCAN_BELOW;
				end
			end
			abff_pkg::ST_SCAN_UP: begin
				cmd.scan_step = 1'b1;
				if (status.scan_hit) begin
					if (status.act == abff_pkg::ACT_FIND) begin
						cmd.emit       = 1'b1;
						cmd.emit_ok    = 1'b1;
						cmd.emit_found = 1'b1;
					end else begin
						cmd.take_low = 1'b1;
						if (!status.idx_is_high) begin
							cmd.emit    = 1'b1;
							cmd.emit_ok = 1'b1;
						end
					end
				end else if (status.scan_end) begin
					cmd.emit = 1'b1;
					if (status.act != abff_pkg::ACT_FIND) begin
						cmd.mark_full = 1'b1;
						cmd.emit_ok   = 1'b1;
					end
				end
			end
			abff_pkg::ST_SCAN_DOWN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_hit) begin
					cmd.take_high = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_ok   = 1'b1;
				end else if (status.scan_end) begin
					cmd.mark_full = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_ok   = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && !status.refill |=> state_q == abff_pkg::ST_IDLE)
		else $error("result issued without returning to idle");

	a_accept_no_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !status.refill)
		else $error("item accepted together with a config write");

	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_init |=> state_q == abff_pkg::ST_SCAN_UP ||
			state_q == abff_pkg::ST_SCAN_DOWN || state_q == abff_pkg::ST_FILL)
		else $error("scan set up but no scan state entered");
`endif

endmodule

// ===== tb/sv/allocation_bitmap_free_finder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_bitmap_free_finder_checker
// Watches the item, result and config channels of the bitmap free finder,
// keeps its own copy of the bitmap and both clear bounds, predicts each
// result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module allocation_bitmap_free_finder_checker #(
	parameter int unsigned MAX_BITS = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  abff_pkg::in_item_t              item,
	input  logic                            done,
	input  abff_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [abff_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abff_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);
	import abff_pkg::*;

	int unsigned bits_in_use_q;
	bit          fill_set_q;
	bit          map_bits [MAX_BITS];
	int unsigned lowest_clear_q;
	int unsigned highest_clear_q;
	out_item_t   pending_results [$];
	int          mismatches = 0;

	assign fail_count = mismatches;
	assign pending    = pending_results.size();

	function automatic int unsigned live_count();
		return (bits_in_use_q > MAX_BITS) ? MAX_BITS : bits_in_use_q;
	endfunction

	function automatic bit map_full(int unsigned n);
		return lowest_clear_q >= n || highest_clear_q >= n;
	endfunction

	// lowest clear bit in [lo, hi], hi clamped to n-1
	function automatic bit clear_above(int unsigned lo, int unsigned hi, int unsigned n,
			output int unsigned hit);
		int unsigned last;
		hit = 0;
		if (lo > hi || lo >= n)
			return 0;
		last = (hi >= n) ? n - 1 : hi;
		for (int unsigned i = lo; i <= last; i++) begin
			if (!map_bits[i]) begin
				hit = i;
				return 1;
			end
		end
		return 0;
	endfunction

	// highest clear bit in [lo, hi], hi clamped to n-1
	function automatic bit clear_below(int unsigned hi, int unsigned lo, int unsigned n,
			output int unsigned hit);
		int top;
		hit = 0;
		if (hi < lo || lo >= n)
			return 0;
		top = (hi >= n) ? int'(n - 1) : int'(hi);
		for (int i = top; i >= int'(lo); i--) begin
			if (!map_bits[i]) begin
				hit = i;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void refill();
		int unsigned n;
		n = live_count();
		foreach (map_bits[i])
			map_bits[i] = fill_set_q;
		lowest_clear_q  = n;
		highest_clear_q = n;
		if (n != 0 && !fill_set_q) begin
			lowest_clear_q  = 0;
			highest_clear_q = n - 1;
		end
	endfunction

	function automatic void mark_map_full(int unsigned n);
		lowest_clear_q  = n;
		highest_clear_q = n;
	endfunction

	function automatic void bounds_after_set(int unsigned idx, int unsigned n);
		int unsigned hit;
		if (map_full(n))
			return;
		if (idx == lowest_clear_q) begin
			if (clear_above(idx + 1, highest_clear_q, n, hit)) begin
				lowest_clear_q = hit;
			end else begin
				mark_map_full(n);
				return;
			end
		end
		if (idx == highest_clear_q) begin
			if (idx > 0 && clear_below(idx - 1, lowest_clear_q, n, hit))
				highest_clear_q = hit;
			else
				mark_map_full(n);
		end
	endfunction

	function automatic out_item_t apply_action(in_item_t it);
		out_item_t   r;
		int unsigned n;
		int unsigned idx;
		int unsigned hit;
		r   = '0;
		n   = live_count();
		idx = it.bit_index;
		if (action_t'(it.action) == ACT_FIND) begin
			if (!map_full(n) && clear_above(lowest_clear_q, highest_clear_q, n, hit)) begin
				r.ok          = 1'b1;
				r.found_index = hit[IDX_W-1:0];
			end
		end else if (idx < n) begin
			r.ok = 1'b1;
			case (action_t'(it.action))
				ACT_GET: begin
					r.bit_value = map_bits[idx];
				end
				ACT_SET: begin
					if (!map_bits[idx]) begin
						map_bits[idx] = 1'b1;
						bounds_after_set(idx, n);
					end
				end
				ACT_CLEAR: begin
					if (map_bits[idx]) begin
						map_bits[idx] = 1'b0;
						if (map_full(n)) begin
							lowest_clear_q  = idx;
							highest_clear_q = idx;
						end else begin
							if (idx < lowest_clear_q)
								lowest_clear_q = idx;
							if (idx > highest_clear_q)
								highest_clear_q = idx;
						end
					end
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

	function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BITS_IN_USE: begin
				bits_in_use_q = data;
				refill();
			end
			REG_FILL_SET: begin
				fill_set_q = data[0];
				refill();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void compare_result(out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			$display("%0t: result beat with no item outstanding: %p", $time, got);
			return;
		end
		want = pending_results.pop_front();
		if (got.ok !== want.ok) begin
			mismatches++;
			$display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
		end
		if (got.bit_value !== want.bit_value) begin
			mismatches++;
			$display("%0t: bit_value expected %0b actual %0b", $time, want.bit_value,
				got.bit_value);
		end
		if (got.found_index !== want.found_index) begin
			mismatches++;
			$display("%0t: found_index expected %0d actual %0d", $time, want.found_index,
				got.found_index);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q = BITS_RST;
			fill_set_q    = 1'b0;
			refill();
			pending_results.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (start && !busy)
				pending_results.push_back(apply_action(item));
			if (done)
				compare_result(result);
		end
	end

endmodule

// ===== tb/sv/allocation_bitmap_free_finder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_bitmap_free_finder_test
// Drives get, set, clear and find items and config writes into the bitmap
// free finder: a directed pass over range limits, bound moves, full and
// empty maps, then random phases over several bit counts and fills with
// indexes aimed at the bounds. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module allocation_bitmap_free_finder_test;
	import abff_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	in_item_t              item;
	logic                  done;
	out_item_t             result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int unsigned           active_bits;

	allocation_bitmap_free_finder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	allocation_bitmap_free_finder_checker map_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		start <= 1'b0;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(int unsigned bits, bit fill);
		logic [CFG_DATA_W-1:0] fill_word;
		fill_word    = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1);
		fill_word[0] = fill;
		cfg_write(REG_BITS_IN_USE, CFG_DATA_W'(bits));
		cfg_write(REG_FILL_SET, fill_word);
		active_bits = (bits > BITS_RST) ? BITS_RST : bits;
	endtask

	task automatic send_item(in_item_t it, bit calm);
		if (!calm && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(5, 1))
				@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic act(action_t a, int unsigned idx);
		in_item_t it;
		it.action    = a;
		it.bit_index = IDX_W'(idx);
		send_item(it, 1'b0);
	endtask

	// indexes mostly in range, often on the edges of big maps where the bounds sit
	function automatic in_item_t random_item(int unsigned n);
		in_item_t    it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15)
			it.action = ACT_GET;
		else if (pick < 50)
			it.action = ACT_SET;
		else if (pick < 75)
			it.action = ACT_CLEAR;
		else
			it.action = ACT_FIND;
		pick = $urandom_range(99);
		if (n == 0 || pick < 8)
			it.bit_index = IDX_W'($urandom);
		else if (n <= 256 || pick >= 70)
			it.bit_index = IDX_W'($urandom_range(n - 1, 0));
		else if (pick < 40)
			it.bit_index = IDX_W'($urandom_range(15, 0));
		else
			it.bit_index = IDX_W'($urandom_range(n - 1, n - 16));
		return it;
	endfunction

	task automatic run_phase(int unsigned bits, bit fill, int unsigned count, bit calm);
		set_config(bits, fill);
		repeat (count)
			send_item(random_item(active_bits), calm);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_BITS_IN_USE;
		cfg_data    = '0;
		active_bits = BITS_RST;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// reset map: all clear, 4096 bits
		act(ACT_GET, 0);
		act(ACT_GET, 4095);
		act(ACT_SET, 0);
		act(ACT_SET, 4095);
		act(ACT_FIND, 0);
		act(ACT_SET, 1);
		act(ACT_CLEAR, 0);
		act(ACT_CLEAR, 0);
		act(ACT_SET, 7);
		act(ACT_SET, 7);
		act(ACT_GET, 7);
		act(ACT_FIND, 4095);
		act(ACT_CLEAR, 4095);

		// empty map: everything fails
		set_config(0, 1'b0);
		act(ACT_GET, 0);
		act(ACT_SET, 3);
		act(ACT_FIND, 0);

		// oversized count, filled set
		set_config(CNT_MAX, 1'b1);
		act(ACT_FIND, 0);
		act(ACT_CLEAR, 100);
		act(ACT_FIND, 0);
		act(ACT_SET, 100);
		act(ACT_FIND, 0);

		set_config(5, 1'b0);
		act(ACT_GET, 5);
		for (int unsigned i = 0; i < 5; i++)
			act(ACT_SET, i);
		act(ACT_FIND, 0);

		cfg_write(REG_SPARE_LO, CFG_DATA_W'($urandom));

		run_phase(BITS_RST, 1'b0, 90, 1'b0);
		run_phase(8, 1'b1, 60, 1'b0);
		run_phase(40, 1'b0, 70, 1'b0);
		cfg_write(REG_SPARE_HI, CFG_DATA_W'($urandom));
		run_phase(CNT_MAX, 1'b1, 80, 1'b1);
		run_phase(130, 1'b0, 80, 1'b0);
		run_phase(1, 1'b0, 30, 1'b0);
		run_phase(65, 1'b1, 60, 1'b0);
		run_phase(BITS_RST, 1'b1, 40, 1'b0);

		start <= 1'b0;
		wait_idle();
		repeat (200)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
